[sv/thtw_pkg.sv]
// Shared types and constants for the TCP header TTL/window rewriter.
package thtw_pkg;

  // EtherType and protocol codes
  localparam logic [15:0] EthIpv4  = 16'h0800;
  localparam logic [15:0] EthIpv6  = 16'h86DD;
  localparam logic [7:0]  ProtoTcp = 8'd6;

  // Register reset values
  localparam logic [7:0]  HopResetVal    = 8'd64;
  localparam logic [15:0] WindowResetVal = 16'hFAF0;

  // Fixed frame offsets
  localparam logic [6:0] V4TtlOffset    = 7'd22;
  localparam logic [6:0] V6HopOffset    = 7'd21;
  localparam logic [6:0] V6WindowOffset = 7'd68;
  localparam logic [6:0] V4WindowBase   = 7'd28;  // 14 + 14, IHL*4 added
  localparam logic [6:0] V4MinLenBase   = 7'd34;  // 14 + 20, IHL*4 added
  localparam logic [16:0] V6MinLen      = 17'd74;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_HOP_VAL = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_reg_t;

  localparam int CfgDataW = 16;

  // Current register contents
  typedef struct packed {
    logic [7:0]  hop_val;
    logic [15:0] window;
  } cfg_t;

  // One descriptor
  typedef struct packed {
    logic        event_valid;
    logic        ip_version;
    logic [6:0]  hop_offset;
    logic [6:0]  window_offset;
    logic [7:0]  hop_value;
    logic [15:0] window_value;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
  } desc_t;

endpackage

[sv/thtw_if.sv]
// Handshake channel interfaces: frame bytes in, descriptors out, register writes.
interface thtw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface thtw_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic        ip_version;
  logic [6:0]  hop_offset;
  logic [6:0]  window_offset;
  logic [7:0]  hop_value;
  logic [15:0] window_value;
  logic [63:0] source_high;
  logic [63:0] source_low;
  logic [63:0] dest_high;
  logic [63:0] dest_low;

  modport source (output valid, output event_valid, output ip_version, output hop_offset,
                  output window_offset, output hop_value, output window_value,
                  output source_high, output source_low, output dest_high,
                  output dest_low, input ready);
  modport sink   (input valid, input event_valid, input ip_version, input hop_offset,
                  input window_offset, input hop_value, input window_value,
                  input source_high, input source_low, input dest_high,
                  input dest_low, output ready);
endinterface

interface thtw_cfg_if;
  logic                          valid;
  logic                          ready;
  thtw_pkg::cfg_reg_t            reg_index;
  logic [thtw_pkg::CfgDataW-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[sv/tcp_header_ttl_window_rewriter.sv]
// Top level: byte input register, frame parser and descriptor output register.
//
//   channel  | dir | payload                                  | item
//   in_bus   | in  | data_byte, last_byte                     | one frame byte
//   out_bus  | out | event_valid .. dest_low                  | one descriptor per frame
//   cfg_bus  | in  | reg_index, wr_data                       | one register write
//
// One byte per clock while no descriptor is stalled; a descriptor is offered once its frame's
// last byte has passed the input register and then the descriptor register.
// rst_n is synchronous: clears frame state, channel valids, and loads register defaults.
// A stalled descriptor (out_bus.valid high, ready low) holds the whole pipeline;
// in_bus.ready follows out_bus.ready combinationally. cfg_bus is always ready.
module tcp_header_ttl_window_rewriter (
  input  logic        clk,
  input  logic        rst_n,
  thtw_in_if.sink     in_bus,
  thtw_out_if.source  out_bus,
  thtw_cfg_if.sink    cfg_bus
);

  thtw_pkg::cfg_t  cfg;
  thtw_pkg::desc_t desc;
  thtw_pkg::desc_t out_r;

  logic       adv;
  logic       step;
  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_valid_r;

  thtw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  // Pipeline moves unless a descriptor waits on the output
  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign step         = adv && in_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_bus.valid) begin
      in_data_r <= in_bus.data_byte;
      in_last_r <= in_bus.last_byte;
    end
  end

  thtw_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .cfg       (cfg),
    .desc      (desc)
  );

  // Descriptor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r && in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_r <= desc;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.event_valid   = out_r.event_valid;
  assign out_bus.ip_version    = out_r.ip_version;
  assign out_bus.hop_offset    = out_r.hop_offset;
  assign out_bus.window_offset = out_r.window_offset;
  assign out_bus.hop_value     = out_r.hop_value;
  assign out_bus.window_value  = out_r.window_value;
  assign out_bus.source_high   = out_r.source_high;
  assign out_bus.source_low    = out_r.source_low;
  assign out_bus.dest_high     = out_r.dest_high;
  assign out_bus.dest_low      = out_r.dest_low;

endmodule

[sv/thtw_cfg_regs.sv]
// Configuration registers: new hop limit and new TCP window.
module thtw_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  thtw_cfg_if.sink          cfg_bus,
  output thtw_pkg::cfg_t    cfg
);

  thtw_pkg::cfg_t cfg_r;

  // Writes are always taken
  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hop_val <= thtw_pkg::HopResetVal;
      cfg_r.window  <= thtw_pkg::WindowResetVal;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.reg_index)
        thtw_pkg::CFG_HOP_VAL: cfg_r.hop_val <= cfg_bus.wr_data[7:0];
        thtw_pkg::CFG_WINDOW:  cfg_r.window  <= cfg_bus.wr_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/thtw_frame_parser.sv]
// Per-frame header tracker; builds the descriptor for the frame's last byte.
module thtw_frame_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,       // registered byte is consumed this cycle
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  thtw_pkg::cfg_t  cfg,
  output thtw_pkg::desc_t desc
);

  logic [15:0] pos_r,    pos_nxt;
  logic [15:0] etype_r,  etype_upd,  etype_nxt;
  logic [3:0]  ihl_r,    ihl_upd,    ihl_nxt;
  logic [7:0]  proto_r,  proto_upd,  proto_nxt;
  logic [63:0] src_hi_r, src_hi_upd, src_hi_nxt;
  logic [63:0] src_lo_r, src_lo_upd, src_lo_nxt;
  logic [63:0] dst_hi_r, dst_hi_upd, dst_hi_nxt;
  logic [63:0] dst_lo_r, dst_lo_upd, dst_lo_nxt;

  logic [16:0] frame_len;
  logic [6:0]  v4_min_len;
  logic [6:0]  v4_win_off;
  logic [63:0] v4_src, v4_dst;
  logic        v4_hit, v6_hit;

  // Field capture for the current byte
  always_comb begin
    etype_upd  = etype_r;
    ihl_upd    = ihl_r;
    proto_upd  = proto_r;
    src_hi_upd = src_hi_r;
    src_lo_upd = src_lo_r;
    dst_hi_upd = dst_hi_r;
    dst_lo_upd = dst_lo_r;
    if (pos_r == 16'd12 || pos_r == 16'd13) begin
      etype_upd = {etype_r[7:0], data_byte};
    end else if (etype_r == thtw_pkg::EthIpv4) begin
      if (pos_r == 16'd14) begin
        ihl_upd = data_byte[3:0];
      end else if (pos_r == 16'd23) begin
        proto_upd = data_byte;
      end else if (pos_r >= 16'd26 && pos_r <= 16'd29) begin
        src_lo_upd = {src_lo_r[55:0], data_byte};
      end else if (pos_r >= 16'd30 && pos_r <= 16'd33) begin
        dst_lo_upd = {dst_lo_r[55:0], data_byte};
      end
    end else if (etype_r == thtw_pkg::EthIpv6) begin
      if (pos_r == 16'd20) begin
        proto_upd = data_byte;
      end else if (pos_r >= 16'd22 && pos_r <= 16'd29) begin
        src_hi_upd = {src_hi_r[55:0], data_byte};
      end else if (pos_r >= 16'd30 && pos_r <= 16'd37) begin
        src_lo_upd = {src_lo_r[55:0], data_byte};
      end else if (pos_r >= 16'd38 && pos_r <= 16'd45) begin
        dst_hi_upd = {dst_hi_r[55:0], data_byte};
      end else if (pos_r >= 16'd46 && pos_r <= 16'd53) begin
        dst_lo_upd = {dst_lo_r[55:0], data_byte};
      end
    end
  end

  // Next state: clear after the last byte, else keep the captured fields
  always_comb begin
    if (last_byte) begin
      pos_nxt    = '0;
      etype_nxt  = '0;
      ihl_nxt    = '0;
      proto_nxt  = '0;
      src_hi_nxt = '0;
      src_lo_nxt = '0;
      dst_hi_nxt = '0;
      dst_lo_nxt = '0;
    end else begin
      pos_nxt    = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
      etype_nxt  = etype_upd;
      ihl_nxt    = ihl_upd;
      proto_nxt  = proto_upd;
      src_hi_nxt = src_hi_upd;
      src_lo_nxt = src_lo_upd;
      dst_hi_nxt = dst_hi_upd;
      dst_lo_nxt = dst_lo_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      etype_r  <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      src_hi_r <= '0;
      src_lo_r <= '0;
      dst_hi_r <= '0;
      dst_lo_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      etype_r  <= etype_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      src_hi_r <= src_hi_nxt;
      src_lo_r <= src_lo_nxt;
      dst_hi_r <= dst_hi_nxt;
      dst_lo_r <= dst_lo_nxt;
    end
  end

  // Length checks and window offset
  assign frame_len  = {1'b0, pos_r} + 17'd1;
  assign v4_min_len = thtw_pkg::V4MinLenBase + {1'b0, ihl_upd, 2'b00};
  assign v4_win_off = thtw_pkg::V4WindowBase + {1'b0, ihl_upd, 2'b00};

  assign v4_hit = (etype_upd == thtw_pkg::EthIpv4) && (proto_upd == thtw_pkg::ProtoTcp) &&
                  (frame_len >= {10'd0, v4_min_len});
  assign v6_hit = (etype_upd == thtw_pkg::EthIpv6) && (proto_upd == thtw_pkg::ProtoTcp) &&
                  (frame_len >= thtw_pkg::V6MinLen);

  // With IHL 0 or 1 the window overlays the low half of an address
  always_comb begin
    v4_src = src_lo_upd;
    v4_dst = dst_lo_upd;
    if (ihl_upd == 4'd0) begin
      v4_src[15:0] = cfg.window;
    end
    if (ihl_upd == 4'd1) begin
      v4_dst[15:0] = cfg.window;
    end
  end

  // Descriptor assembly
  always_comb begin
    desc = '0;
    if (v4_hit) begin
      desc.event_valid   = 1'b1;
      desc.ip_version    = 1'b0;
      desc.hop_offset    = thtw_pkg::V4TtlOffset;
      desc.window_offset = v4_win_off;
      desc.hop_value     = cfg.hop_val;
      desc.window_value  = cfg.window;
      desc.source_low    = v4_src;
      desc.dest_low      = v4_dst;
    end else if (v6_hit) begin
      desc.event_valid   = 1'b1;
      desc.ip_version    = 1'b1;
      desc.hop_offset    = thtw_pkg::V6HopOffset;
      desc.window_offset = thtw_pkg::V6WindowOffset;
      desc.hop_value     = cfg.hop_val;
      desc.window_value  = cfg.window;
      desc.source_high   = src_hi_upd;
      desc.source_low    = src_lo_upd;
      desc.dest_high     = dst_hi_upd;
      desc.dest_low      = dst_lo_upd;
    end
  end

endmodule
